FILE: rtl/mips_subset_execute_top_defines.svh
// Assertion macros shared by the execute block.
`ifndef MIPS_SUBSET_EXECUTE_TOP_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mse_pkg.sv
// Package with opcodes, function codes, status codes and shared types of the execute block.
`default_nettype none
package mse_pkg;

   localparam logic [5:0] OpRtype = 6'h00;
   localparam logic [5:0] OpJ     = 6'h02;
   localparam logic [5:0] OpJal   = 6'h03;
   localparam logic [5:0] OpBeq   = 6'h04;
   localparam logic [5:0] OpBne   = 6'h05;
   localparam logic [5:0] OpAddi  = 6'h08;
   localparam logic [5:0] OpSlti  = 6'h0a;
   localparam logic [5:0] OpAndi  = 6'h0c;
   localparam logic [5:0] OpOri   = 6'h0d;
   localparam logic [5:0] OpLw    = 6'h23;
   localparam logic [5:0] OpSw    = 6'h2b;

   localparam logic [5:0] FnSll = 6'h00;
   localparam logic [5:0] FnSrl = 6'h02;
   localparam logic [5:0] FnSra = 6'h03;
   localparam logic [5:0] FnJr  = 6'h08;
   localparam logic [5:0] FnAdd = 6'h20;
   localparam logic [5:0] FnSub = 6'h22;
   localparam logic [5:0] FnAnd = 6'h24;
   localparam logic [5:0] FnOr  = 6'h25;
   localparam logic [5:0] FnNor = 6'h27;
   localparam logic [5:0] FnSlt = 6'h2a;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusHalt    = 2'd1;
   localparam logic [1:0] StatusUnknown = 2'd2;

   localparam logic [31:0] HaltWord = 32'hffff_ffff;
   localparam logic [31:0] PcReset  = 32'h0000_1000;
   localparam logic [31:0] SpReset  = 32'h0000_8000;
   localparam logic [4:0]  SpIndex  = 5'd29;
   localparam logic [4:0]  RaIndex  = 5'd31;
   localparam logic [4:0]  ZeroIndex = 5'd0;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_written;
      logic [15:0] mem_address;
      logic [31:0] mem_value;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic        rd;
      logic        wr;
      logic [31:0] addr;
      logic [31:0] wdata;
   } dmem_cmd_type;

endpackage
`default_nettype wire

FILE: rtl/mse_req_if.sv
// Request channel: one instruction word with valid and ready.
`default_nettype none
interface mse_req_if ();
   logic        valid;
   logic        ready;
   logic [31:0] instruction;

   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface
`default_nettype wire

FILE: rtl/mse_rsp_if.sv
// Response channel: the execution result of one instruction with valid and ready.
`default_nettype none
interface mse_rsp_if ();
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        reg_written;
   logic [4:0]  reg_index;
   logic [31:0] reg_value;
   logic        mem_written;
   logic [15:0] mem_address;
   logic [31:0] mem_value;
   logic [1:0]  status;

   modport source (output valid, output next_pc, output reg_written, output reg_index,
                   output reg_value, output mem_written, output mem_address,
                   output mem_value, output status, input ready);
   modport sink (input valid, input next_pc, input reg_written, input reg_index,
                 input reg_value, input mem_written, input mem_address,
                 input mem_value, input status, output ready);
endinterface
`default_nettype wire

FILE: rtl/mips_subset_execute_top.sv
// Top level of the MIPS32 subset execute block.
//
// The block takes one 32-bit instruction word per request on the req_if channel and
// returns one result per request on the rsp_if channel, in order. Both channels use a
// valid/ready handshake; a request moves at a rising edge with valid and ready high.
// The register file is a 32-entry memory read when a request is accepted, so the
// operands come out in the cycle after; an instruction then executes combinationally
// from them and its result is held in an output register. A load word reads the
// byte-banked data memory in the execute cycle and writes back from the load write-back
// stage once the output register can take the result, forwarding the loaded value to
// a following request. A new request waits while the operand stage is occupied: the
// stage holds one request at a time and ready stays low until it empties.
// After reset the program counter is 0x1000, the stack pointer reads 0x8000 and the
// data memory is cleared in a pass over 2^(MEM_ADDR_BITS-2) rows, one row of four
// bytes per cycle (16384 rows by default); ready stays low until the pass is done.
// When the receiver stalls, the result waits in the output register and one further
// instruction may finish up to that point before ready drops.
`default_nettype none
`include "mips_subset_execute_top_defines.svh"
module mips_subset_execute_top import mse_pkg::*; #(
   parameter int MEM_ADDR_BITS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   mse_req_if.sink   req_if,
   mse_rsp_if.source rsp_if
);

   localparam logic [31:0] MemMask = 32'((64'd1 << MEM_ADDR_BITS) - 64'd1);

   // Register file memory; entries never written read as their reset value.
   logic [31:0] rf_mem [32];
   logic [31:0] rf_valid_ff;
   logic        rf_we;
   logic [4:0]  rf_widx;
   logic [31:0] rf_wdata;

   // Operand stage.
   logic        s1_valid_ff;
   logic [31:0] ins_ff;
   logic [31:0] rf_a_ff, rf_b_ff;
   logic        va_ff, vb_ff, sa_ff, sb_ff, fa_ff, fb_ff;
   logic [31:0] fwd_ff;
   logic [31:0] pc_ff;

   // Load write-back stage.
   logic        w_valid_ff;
   logic [4:0]  w_idx_ff;
   logic [31:0] w_addr_ff;
   logic [31:0] w_pc_ff;

   // Output register.
   logic        out_valid_ff;
   rsp_type     out_ff;

   logic         accept, out_can, s1_go, w_done, clear_done;
   logic [4:0]   req_rs, req_rt;
   logic [31:0]  load_data;
   dmem_cmd_type dmem_cmd;

   // Execute decode.
   logic [5:0]  op, fn;
   logic [4:0]  rt_f, rd_f, sh;
   logic [31:0] a, b, si, zi, pc4, npc, ea;
   logic        wr, mw, is_lw;
   logic [4:0]  widx;
   logic [31:0] wval;
   logic [1:0]  status;
   logic        ex_wr;

   assign req_rs  = req_if.instruction[25:21];
   assign req_rt  = req_if.instruction[20:16];
   assign out_can = !out_valid_ff || rsp_if.ready;
   assign w_done  = w_valid_ff && out_can;
   assign req_if.ready = clear_done && !s1_valid_ff && (!w_valid_ff || out_can);
   assign accept  = req_if.valid && req_if.ready;
   assign s1_go   = s1_valid_ff && (is_lw || out_can);

   // Operand read with reset-value and load-forward selection.
   always_ff @(posedge clock) begin
      if (accept) begin
         ins_ff  <= req_if.instruction;
         rf_a_ff <= rf_mem[req_rs];
         rf_b_ff <= rf_mem[req_rt];
         va_ff   <= rf_valid_ff[req_rs];
         vb_ff   <= rf_valid_ff[req_rt];
         sa_ff   <= (req_rs == SpIndex);
         sb_ff   <= (req_rt == SpIndex);
         fa_ff   <= w_done && (w_idx_ff != ZeroIndex) && (w_idx_ff == req_rs);
         fb_ff   <= w_done && (w_idx_ff != ZeroIndex) && (w_idx_ff == req_rt);
         fwd_ff  <= load_data;
      end
   end

   assign a = fa_ff ? fwd_ff : (va_ff ? rf_a_ff : (sa_ff ? SpReset : '0));
   assign b = fb_ff ? fwd_ff : (vb_ff ? rf_b_ff : (sb_ff ? SpReset : '0));

   assign op   = ins_ff[31:26];
   assign rt_f = ins_ff[20:16];
   assign rd_f = ins_ff[15:11];
   assign sh   = ins_ff[10:6];
   assign fn   = ins_ff[5:0];
   assign si   = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign zi   = {16'd0, ins_ff[15:0]};
   assign pc4  = pc_ff + 32'd4;
   assign ea   = (a + si) & MemMask;

   always_comb begin
      wr     = 1'b0;
      mw     = 1'b0;
      is_lw  = 1'b0;
      widx   = ZeroIndex;
      wval   = '0;
      status = StatusOk;
      npc    = pc4;
      if (ins_ff == HaltWord) begin
         status = StatusHalt;
      end else begin
         unique case (op)
            OpRtype: begin
               wr   = 1'b1;
               widx = rd_f;
               unique case (fn)
                  FnAdd: wval = a + b;
                  FnSub: wval = a - b;
                  FnAnd: wval = a & b;
                  FnOr:  wval = a | b;
                  FnNor: wval = ~(a | b);
                  FnSlt: wval = {31'd0, $signed(a) < $signed(b)};
                  FnSll: wval = b << sh;
                  FnSrl: wval = b >> sh;
                  FnSra: wval = 32'($signed(b) >>> sh);
                  FnJr: begin
                     wr  = 1'b0;
                     npc = a;
                  end
                  default: begin
                     wr     = 1'b0;
                     status = StatusUnknown;
                  end
               endcase
            end
            OpAddi: begin
               wr = 1'b1; widx = rt_f; wval = a + si;
            end
            OpAndi: begin
               wr = 1'b1; widx = rt_f; wval = a & zi;
            end
            OpOri: begin
               wr = 1'b1; widx = rt_f; wval = a | zi;
            end
            OpSlti: begin
               wr = 1'b1; widx = rt_f; wval = {31'd0, $signed(a) < $signed(si)};
            end
            OpLw: begin
               is_lw = 1'b1;
               widx  = rt_f;
            end
            OpSw: mw = 1'b1;
            OpBeq: begin
               if (a == b) begin
                  npc = pc4 + {si[29:0], 2'b00};
               end
            end
            OpBne: begin
               if (a != b) begin
                  npc = pc4 + {si[29:0], 2'b00};
               end
            end
            OpJ: npc = {pc4[31:28], ins_ff[25:0], 2'b00};
            OpJal: begin
               wr   = 1'b1;
               widx = RaIndex;
               wval = pc4;
               npc  = {pc4[31:28], ins_ff[25:0], 2'b00};
            end
            default: status = StatusUnknown;
         endcase
      end
   end

   assign ex_wr = wr && (widx != ZeroIndex);

   // Single register file write port: execute and load write-back never coincide.
   always_comb begin
      rf_we    = 1'b0;
      rf_widx  = w_idx_ff;
      rf_wdata = load_data;
      if (w_done) begin
         rf_we = (w_idx_ff != ZeroIndex);
      end else if (s1_go && ex_wr) begin
         rf_we    = 1'b1;
         rf_widx  = widx;
         rf_wdata = wval;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_widx] <= rf_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (rf_we) begin
         rf_valid_ff[rf_widx] <= 1'b1;
      end
   end

   // Data memory access: a held load re-reads its address until the result slot frees.
   always_comb begin
      dmem_cmd.rd    = (s1_go && is_lw) || w_valid_ff;
      dmem_cmd.wr    = s1_go && mw;
      dmem_cmd.addr  = (s1_go && (is_lw || mw)) ? ea : w_addr_ff;
      dmem_cmd.wdata = b;
   end

   mse_dmem #(
      .MEM_ADDR_BITS(MEM_ADDR_BITS)
   ) u_dmem (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dmem_cmd),
      .rdata      (load_data),
      .clear_done (clear_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         w_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= PcReset;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go && is_lw) begin
            w_valid_ff <= 1'b1;
         end else if (w_done) begin
            w_valid_ff <= 1'b0;
         end
         if ((s1_go && !is_lw) || w_done) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            pc_ff <= npc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && is_lw) begin
         w_idx_ff  <= widx;
         w_addr_ff <= ea;
         w_pc_ff   <= npc;
      end
   end

   always_ff @(posedge clock) begin
      if (w_done) begin
         out_ff.next_pc     <= w_pc_ff;
         out_ff.reg_written <= (w_idx_ff != ZeroIndex);
         out_ff.reg_index   <= w_idx_ff;
         out_ff.reg_value   <= (w_idx_ff != ZeroIndex) ? load_data : '0;
         out_ff.mem_written <= 1'b0;
         out_ff.mem_address <= '0;
         out_ff.mem_value   <= '0;
         out_ff.status      <= StatusOk;
      end else if (s1_go && !is_lw) begin
         out_ff.next_pc     <= npc;
         out_ff.reg_written <= ex_wr;
         out_ff.reg_index   <= ex_wr ? widx : ZeroIndex;
         out_ff.reg_value   <= ex_wr ? wval : '0;
         out_ff.mem_written <= mw;
         out_ff.mem_address <= mw ? ea[15:0] : '0;
         out_ff.mem_value   <= mw ? b : '0;
         out_ff.status      <= status;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.next_pc     = out_ff.next_pc;
   assign rsp_if.reg_written = out_ff.reg_written;
   assign rsp_if.reg_index   = out_ff.reg_index;
   assign rsp_if.reg_value   = out_ff.reg_value;
   assign rsp_if.mem_written = out_ff.mem_written;
   assign rsp_if.mem_address = out_ff.mem_address;
   assign rsp_if.mem_value   = out_ff.mem_value;
   assign rsp_if.status      = out_ff.status;

   // The operand stage and the load write-back stage are never busy together.
   `MSE_ASSERT_SAME(a_stage_excl, clock, reset, s1_valid_ff, !w_valid_ff, "stage overlap")
   // No request is taken while the data memory is being cleared.
   `MSE_ASSERT_SAME(a_no_accept_clear, clock, reset, accept, clear_done, "accept in clear")
   // A finished non-load instruction always leaves a result in the output register.
   `MSE_ASSERT_NEXT(a_result_out, clock, reset, s1_go && !is_lw, out_valid_ff, "lost result")

endmodule
`default_nettype wire

FILE: rtl/mse_dmem.sv
// Byte-addressed data memory in four byte banks with a clearing pass after reset.
`default_nettype none
module mse_dmem import mse_pkg::*; #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dmem_cmd_type cmd,
   output logic [31:0]       rdata,
   output logic              clear_done
);

   localparam int RowBits = MEM_ADDR_BITS - 2;
   localparam int Rows    = 1 << RowBits;

   logic [RowBits:0]         clr_ff;
   logic [RowBits:0]         clr_in;
   logic [MEM_ADDR_BITS-1:0] addr_n;
   logic [1:0]               off_ff;
   logic [7:0]               q_ff [4];

   assign addr_n     = cmd.addr[MEM_ADDR_BITS-1:0];
   assign clear_done = clr_ff[RowBits];
   assign clr_in     = clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (!clear_done) begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         off_ff <= addr_n[1:0];
      end
   end

   // Byte j of a word lands in bank (addr + j) mod 4, so each bank sees one byte.
   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [7:0]               bank_mem [Rows];
      logic [1:0]               sel;
      logic [MEM_ADDR_BITS-1:0] byte_addr;
      logic [RowBits-1:0]       row;
      logic [7:0]               wbyte;

      assign sel       = 2'(k) - addr_n[1:0];
      assign byte_addr = addr_n + MEM_ADDR_BITS'(sel);
      assign row       = byte_addr[MEM_ADDR_BITS-1:2];
      assign wbyte     = 8'(cmd.wdata >> {~sel, 3'b000});

      always_ff @(posedge clock) begin
         if (!clear_done) begin
            bank_mem[clr_ff[RowBits-1:0]] <= '0;
         end else if (cmd.wr) begin
            bank_mem[row] <= wbyte;
         end
         if (cmd.rd) begin
            q_ff[k] <= bank_mem[row];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         rdata[31 - 8*j -: 8] = q_ff[2'(off_ff + 2'(j))];
      end
   end

endmodule
`default_nettype wire

FILE: tb/sv/mips_subset_execute_top_test.sv
// Self-checking testbench for the MIPS32 subset execute block.
`default_nettype none
module mips_subset_execute_top_test;
   import mse_pkg::*;

   // The limit covers the data memory clear pass after reset plus every request waiting
   // out long sender gaps and receiver stalls.
   localparam int CycleLimit = 1_000_000;
   localparam int DrainCycles = 20;
   localparam int RandomPerPhase = 380;

   logic clock;
   logic reset;

   mse_req_if req_if ();
   mse_rsp_if rsp_if ();

   mips_subset_execute_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Architectural state as the block should hold it after each accepted request.
   logic [31:0] gpr [32];
   logic [31:0] pc_model;
   logic [7:0]  dmem_model [65536];

   rsp_type expected_results [$];
   int          mismatch_count;
   int          idle_pct;
   int          stall_pct;
   int unsigned cycle_count;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // The cycle counter ends a hung run with the failure message.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // The receiver stalls at the rate set for the current phase.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %h, expected %h", field, got, want);
      mismatch_count++;
   endtask

   // Every accepted result is compared against the oldest predicted one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, next_pc", rsp_if.next_pc, 32'h0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.next_pc !== want.next_pc)
               report_mismatch("next_pc", rsp_if.next_pc, want.next_pc);
            if (rsp_if.reg_written !== want.reg_written)
               report_mismatch("reg_written", 32'(rsp_if.reg_written),
                               32'(want.reg_written));
            if (rsp_if.reg_index !== want.reg_index)
               report_mismatch("reg_index", 32'(rsp_if.reg_index), 32'(want.reg_index));
            if (rsp_if.reg_value !== want.reg_value)
               report_mismatch("reg_value", rsp_if.reg_value, want.reg_value);
            if (rsp_if.mem_written !== want.mem_written)
               report_mismatch("mem_written", 32'(rsp_if.mem_written),
                               32'(want.mem_written));
            if (rsp_if.mem_address !== want.mem_address)
               report_mismatch("mem_address", 32'(rsp_if.mem_address),
                               32'(want.mem_address));
            if (rsp_if.mem_value !== want.mem_value)
               report_mismatch("mem_value", rsp_if.mem_value, want.mem_value);
            if (rsp_if.status !== want.status)
               report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
         end
      end
   end

   function automatic rsp_type execute_instruction(input logic [31:0] word);
      rsp_type     r;
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sh;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] simm;
      logic [31:0] zimm;
      logic [31:0] pc4;
      logic [15:0] addr;
      logic        wr;
      r = '0;
      op = word[31:26];
      rs = word[25:21];
      rt = word[20:16];
      rd = word[15:11];
      sh = word[10:6];
      fn = word[5:0];
      a = gpr[rs];
      b = gpr[rt];
      simm = {{16{word[15]}}, word[15:0]};
      zimm = {16'h0, word[15:0]};
      pc_model = pc_model + 32'd4;
      pc4 = pc_model;
      wr = 1'b0;
      if (word == HaltWord) begin
         r.status = StatusHalt;
      end else if (op == OpRtype) begin
         wr = 1'b1;
         r.reg_index = rd;
         case (fn)
            FnAdd: r.reg_value = a + b;
            FnSub: r.reg_value = a - b;
            FnAnd: r.reg_value = a & b;
            FnOr: r.reg_value = a | b;
            FnNor: r.reg_value = ~(a | b);
            FnSlt: r.reg_value = {31'h0, $signed(a) < $signed(b)};
            FnSll: r.reg_value = b << sh;
            FnSrl: r.reg_value = b >> sh;
            FnSra: r.reg_value = $unsigned($signed(b) >>> sh);
            FnJr: begin
               wr = 1'b0;
               pc_model = a;
            end
            default: begin
               wr = 1'b0;
               r.status = StatusUnknown;
            end
         endcase
      end else begin
         r.reg_index = rt;
         case (op)
            OpAddi: begin
               wr = 1'b1;
               r.reg_value = a + simm;
            end
            OpAndi: begin
               wr = 1'b1;
               r.reg_value = a & zimm;
            end
            OpOri: begin
               wr = 1'b1;
               r.reg_value = a | zimm;
            end
            OpSlti: begin
               wr = 1'b1;
               r.reg_value = {31'h0, $signed(a) < $signed(simm)};
            end
            OpLw: begin
               // Big-endian read; each byte address wraps on its own.
               wr = 1'b1;
               addr = a[15:0] + simm[15:0];
               r.reg_value = {dmem_model[addr], dmem_model[16'(addr + 1)],
                              dmem_model[16'(addr + 2)], dmem_model[16'(addr + 3)]};
            end
            OpSw: begin
               addr = a[15:0] + simm[15:0];
               r.mem_written = 1'b1;
               r.mem_address = addr;
               r.mem_value = b;
               dmem_model[addr] = b[31:24];
               dmem_model[16'(addr + 1)] = b[23:16];
               dmem_model[16'(addr + 2)] = b[15:8];
               dmem_model[16'(addr + 3)] = b[7:0];
            end
            OpBeq: if (a == b) pc_model = pc4 + (simm << 2);
            OpBne: if (a != b) pc_model = pc4 + (simm << 2);
            OpJ: pc_model = {pc4[31:28], word[25:0], 2'b00};
            OpJal: begin
               wr = 1'b1;
               r.reg_index = RaIndex;
               r.reg_value = pc4;
               pc_model = {pc4[31:28], word[25:0], 2'b00};
            end
            default: r.status = StatusUnknown;
         endcase
      end
      // Writes to register zero are dropped and reported as no write at all.
      if (wr && r.reg_index != ZeroIndex) begin
         gpr[r.reg_index] = r.reg_value;
         r.reg_written = 1'b1;
      end else begin
         r.reg_index = ZeroIndex;
         r.reg_value = '0;
      end
      r.next_pc = pc_model;
      return r;
   endfunction

   // Sends one request. Valid is only lowered during an idle cycle, so back-to-back
   // requests never lower and raise it within the same step.
   task automatic send_instruction(input logic [31:0] word);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.instruction <= word;
      expected_results.push_back(execute_instruction(word));
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] r_word(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sh);
      return {OpRtype, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   // Builds a random request, weighted toward well-formed instructions whose operands
   // mostly live in a handful of registers so that results feed later requests.
   function automatic logic [31:0] random_instruction();
      logic [5:0] rfn [10];
      logic [5:0] iop [10];
      logic [4:0] rs;
      logic [4:0] rt;
      logic [4:0] rd;
      logic [15:0] imm;
      int pick;
      rfn = '{FnAdd, FnSub, FnAnd, FnOr, FnNor, FnSlt, FnSll, FnSrl, FnSra, FnJr};
      iop = '{OpAddi, OpAndi, OpOri, OpSlti, OpLw, OpSw, OpBeq, OpBne, OpJ, OpJal};
      rs = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
      rt = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
      rd = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
      imm = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 3) return $urandom;
      if (pick < 4) return HaltWord;
      if (pick < 40) return r_word(rfn[$urandom_range(9)], rs, rt, rd, 5'($urandom));
      if (pick < 65) begin
         // Half of the loads and stores go near the stack pointer to hit stored data.
         if ($urandom_range(1) == 0) begin
            rs = SpIndex;
            imm = 16'($urandom_range(32)) - 16'd16;
         end
         return i_word(($urandom_range(1) == 0) ? OpLw : OpSw, rs, rt, imm);
      end
      return i_word(iop[$urandom_range(9)], rs, rt, imm);
   endfunction

   task automatic test_directed();
      // Reset state: the stack pointer is stored and read back, register zero is zero.
      send_instruction(i_word(OpSw, SpIndex, SpIndex, 16'h0000));
      send_instruction(i_word(OpLw, ZeroIndex, 5'd1, 16'h8000));
      send_instruction(i_word(OpAddi, ZeroIndex, ZeroIndex, 16'h1234));
      send_instruction(i_word(OpAddi, ZeroIndex, 5'd2, 16'hffff));
      send_instruction(i_word(OpOri, ZeroIndex, 5'd3, 16'hffff));
      send_instruction(i_word(OpAndi, 5'd2, 5'd4, 16'h8001));
      send_instruction(i_word(OpSlti, 5'd2, 5'd5, 16'h0000));
      send_instruction(r_word(FnSll, 5'd0, 5'd2, 5'd6, 5'd31));
      send_instruction(r_word(FnSra, 5'd0, 5'd6, 5'd7, 5'd31));
      send_instruction(r_word(FnSrl, 5'd0, 5'd6, 5'd8, 5'd31));
      send_instruction(r_word(FnAdd, 5'd6, 5'd6, 5'd9, 5'd0));
      send_instruction(r_word(FnSub, 5'd0, 5'd6, 5'd10, 5'd0));
      send_instruction(r_word(FnNor, 5'd2, 5'd0, 5'd11, 5'd0));
      send_instruction(r_word(FnSlt, 5'd6, 5'd3, 5'd12, 5'd0));
      // Store across the top of memory so the word wraps to address zero.
      send_instruction(i_word(OpSw, 5'd2, 5'd3, 16'hfffe));
      send_instruction(i_word(OpLw, ZeroIndex, 5'd13, 16'hfffe));
      send_instruction(i_word(OpBeq, 5'd2, 5'd2, 16'hfffe));
      send_instruction(i_word(OpBne, 5'd2, 5'd2, 16'h7fff));
      send_instruction({OpJal, 26'h3ff_ffff});
      send_instruction({OpJ, 26'h000_0000});
      send_instruction(r_word(FnJr, 5'd2, 5'd0, 5'd0, 5'd0));
      send_instruction(HaltWord);
      send_instruction(i_word(6'h3f, 5'd1, 5'd1, 16'h0000));
      send_instruction(r_word(6'h3f, 5'd1, 5'd1, 5'd1, 5'd0));
   endtask

   task automatic test_random(input int idle, input int stall);
      idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < RandomPerPhase; i++) send_instruction(random_instruction());
   endtask

   // The sender holds off until every outstanding result has come back.
   task automatic test_drain_pause();
      wait_for_results();
      for (int i = 0; i < 10; i++) send_instruction(random_instruction());
   endtask

   initial begin
      mismatch_count = 0;
      cycle_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      foreach (gpr[i]) gpr[i] = '0;
      gpr[SpIndex] = SpReset;
      pc_model = PcReset;
      foreach (dmem_model[i]) dmem_model[i] = '0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.instruction = '0;
      rsp_if.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(0, 0);
      test_random(81, 0);
      test_drain_pause();
      test_random(0, 81);
      test_random(11, 11);

      wait_for_results();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/mse_pkg.sv
rtl/mse_req_if.sv
rtl/mse_rsp_if.sv
rtl/mse_dmem.sv
rtl/mips_subset_execute_top.sv
tb/sv/mips_subset_execute_top_test.sv
